/* sv/ttkc_pkg.sv */
// ----------------------------------------------------------------------------
// ttkc_pkg
// Shared types and constants for the turntable key input conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package ttkc_pkg;

	localparam int NUM_KEYS_DEF = 11;
	localparam int SLOW_KEY     = 7;
	localparam int CFG_DW       = 32;
	localparam int CFG_AW       = 5;

	localparam logic        MODE_RESET     = 1'b0;
	localparam logic [2:0]  STEP_RESET     = 3'd1;
	localparam logic [7:0]  DEBOUNCE_RESET = 8'd20;
	localparam logic [9:0]  IDLE_RESET     = 10'd150;
	localparam logic [15:0] PRESENT_RESET  = 16'h01FF;

	localparam logic [7:0]        WHEEL_BIAS = 8'h80;
	localparam logic signed [7:0] AXIS_UP    = 8'sh7F;
	localparam logic signed [7:0] AXIS_DOWN  = 8'sh80;
	localparam logic signed [7:0] AXIS_ZERO  = 8'sh00;

	typedef enum logic [2:0] {
		REG_MODE     = 3'd0,
		REG_STEP     = 3'd1,
		REG_DEBOUNCE = 3'd2,
		REG_IDLE     = 3'd3,
		REG_PRESENT  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_DOWN = 2'd0,
		DIR_IDLE = 2'd1,
		DIR_UP   = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		CHK_0   = 2'd0,
		CHK_1   = 2'd1,
		CHK_DUE = 2'd2
	} chk_t;

	typedef struct packed {
		logic       mode;
		logic [2:0] step;
		logic [9:0] idle_limit;
	} scr_cfg_t;

	typedef struct packed {
		logic phase_a;
		logic phase_b;
		logic tick;
		logic slow_held;
	} scr_in_t;

endpackage

`default_nettype wire

/* sv/ttkc_key_lane.sv */
// ----------------------------------------------------------------------------
// ttkc_key_lane
// Debounce lane for one key: settle counter and accepted key level.
// ----------------------------------------------------------------------------
`default_nettype none

module ttkc_key_lane (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,
	input  wire logic       present,
	input  wire logic       level,
	input  wire logic       tick,
	input  wire logic [7:0] debounce_ms,
	output logic            pressed
);
	import ttkc_pkg::*;

	logic       state_q;
	logic [7:0] settle_q;
	logic [7:0] settle_inc;
	logic       take;
	logic       state_d;
	logic [7:0] settle_d;

	always_comb begin
		settle_inc = (tick && (settle_q < debounce_ms)) ? settle_q + 8'd1 : settle_q;
		take       = (level != state_q) && (settle_inc >= debounce_ms);
		state_d    = take ? level : state_q;
		settle_d   = take ? 8'd0 : settle_inc;
		pressed    = present && !state_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= 1'b1;
			settle_q <= DEBOUNCE_RESET;
		end else if (advance && present) begin
			state_q  <= state_d;
			settle_q <= settle_d;
		end
	end

endmodule

`default_nettype wire

/* sv/ttkc_scratch.sv */
// ----------------------------------------------------------------------------
// ttkc_scratch
// Wheel position tracking from the phase pair and scratch direction check.
// ----------------------------------------------------------------------------
`default_nettype none

module ttkc_scratch (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              advance,
	input  ttkc_pkg::scr_in_t      smp,
	input  ttkc_pkg::scr_cfg_t     cfg,
	output logic signed [7:0]      x_axis,
	output logic signed [7:0]      y_axis
);
	import ttkc_pkg::*;

	logic [7:0] wheel_q;
	logic       prev_valid_q;
	logic       prev_a_q;
	logic [7:0] prev_pos_q;
	dir_t       dir_q;
	logic [9:0] idle_q;
	chk_t       chk_q;

	logic [7:0] step;
	logic [7:0] wheel_d;
	chk_t       chk_inc;
	chk_t       chk_d;
	logic       run;
	dir_t       dir_d;
	logic [9:0] idle_d;
	logic [7:0] prev_pos_d;

	always_comb begin
		step    = smp.slow_held ? 8'd1 : {5'd0, cfg.step};
		wheel_d = wheel_q;
		if (prev_valid_q && (smp.phase_a != prev_a_q)) begin
			wheel_d = (smp.phase_a == smp.phase_b) ? wheel_q + step : wheel_q - step;
		end

		chk_inc = (smp.tick && (chk_q != CHK_DUE)) ? chk_t'(chk_q + 2'd1) : chk_q;
		run     = (chk_inc == CHK_DUE);
		chk_d   = run ? CHK_0 : chk_inc;

		dir_d      = dir_q;
		idle_d     = idle_q;
		prev_pos_d = prev_pos_q;
		if (run) begin
			prev_pos_d = wheel_d;
			if (wheel_d != prev_pos_q) begin
				idle_d = 10'd0;
				if (wheel_d > prev_pos_q) begin
					dir_d = ((wheel_d - prev_pos_q) > 8'd127) ? DIR_DOWN : DIR_UP;
				end else begin
					dir_d = ((prev_pos_q - wheel_d) > 8'd127) ? DIR_UP : DIR_DOWN;
				end
			end else if (idle_q >= cfg.idle_limit) begin
				dir_d = DIR_IDLE;
			end else begin
				idle_d = idle_q + 10'd1;
			end
		end

		if (!cfg.mode) begin
			x_axis = signed'(wheel_d ^ WHEEL_BIAS);
			y_axis = AXIS_ZERO;
		end else begin
			x_axis = AXIS_ZERO;
			case (dir_d)
				DIR_UP:   y_axis = AXIS_UP;
				DIR_DOWN: y_axis = AXIS_DOWN;
				default:  y_axis = AXIS_ZERO;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_q      <= 8'd0;
			prev_valid_q <= 1'b0;
			prev_a_q     <= 1'b0;
			prev_pos_q   <= 8'd0;
			dir_q        <= DIR_IDLE;
			idle_q       <= 10'd0;
			chk_q        <= CHK_DUE;
		end else if (advance) begin
			wheel_q      <= wheel_d;
			prev_valid_q <= 1'b1;
			prev_a_q     <= smp.phase_a;
			prev_pos_q   <= prev_pos_d;
			dir_q        <= dir_d;
			idle_q       <= idle_d;
			chk_q        <= chk_d;
		end
	end

endmodule

`default_nettype wire

/* sv/turntable_key_input_conditioner.sv */
// ----------------------------------------------------------------------------
// turntable_key_input_conditioner
// Per-key debounce lanes plus wheel tracking, merged into one report item.
//
//   channel   dir  handshake               payload
//   s_axis    in   tvalid/tready           key_levels, phase_a, phase_b, ms_tick
//   m_axis    out  tvalid/tready           buttons, x_axis, y_axis
//   apb       in   psel/penable/pready     scratch_mode .. key_present at 4*i
//
// One item per cycle while the report side is not stalled; each report is registered and
// appears in the cycle after its sample. The sample is taken whenever the report register
// is empty or being taken. A stalled report holds in the output register and blocks only new samples.
// Reset sets key lanes to released, resets wheel state and clears the report valid flag (report data has no reset).
// ----------------------------------------------------------------------------
`default_nettype none

module turntable_key_input_conditioner #(
	parameter int NUM_KEYS = ttkc_pkg::NUM_KEYS_DEF,
	localparam int IN_W  = ((NUM_KEYS + 3 + 7) / 8) * 8,
	localparam int OUT_W = ((NUM_KEYS + 16 + 7) / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// key_levels, phase_a, phase_b, ms_tick, zero fill
	input  wire logic [IN_W-1:0]             s_axis_tdata,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// buttons, x_axis, y_axis, zero fill
	output logic [OUT_W-1:0]                 m_axis_tdata,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ttkc_pkg::CFG_AW-1:0] paddr,
	input  wire logic [ttkc_pkg::CFG_DW-1:0] pwdata,
	output logic [ttkc_pkg::CFG_DW-1:0]      prdata,
	output logic                             pready
);
	import ttkc_pkg::*;

	logic                mode_q;
	logic [2:0]          step_q;
	logic [7:0]          debounce_q;
	logic [9:0]          idle_lim_q;
	logic [NUM_KEYS-1:0] present_q;

	logic                cfg_wr;
	reg_idx_t            cfg_idx;

	logic                advance;
	logic [NUM_KEYS-1:0] levels;
	logic                tick;
	logic [NUM_KEYS-1:0] pressed;
	scr_in_t             smp;
	scr_cfg_t            scfg;
	logic signed [7:0]   x_axis;
	logic signed [7:0]   y_axis;

	logic                m_valid_q;
	logic [OUT_W-1:0]    m_data_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_RESET;
			step_q     <= STEP_RESET;
			debounce_q <= DEBOUNCE_RESET;
			idle_lim_q <= IDLE_RESET;
			present_q  <= PRESENT_RESET[NUM_KEYS-1:0];
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MODE:     mode_q     <= pwdata[0];
				REG_STEP:     step_q     <= pwdata[2:0];
				REG_DEBOUNCE: debounce_q <= pwdata[7:0];
				REG_IDLE:     idle_lim_q <= pwdata[9:0];
				REG_PRESENT:  present_q  <= pwdata[NUM_KEYS-1:0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			REG_MODE:     prdata = CFG_DW'(mode_q);
			REG_STEP:     prdata = CFG_DW'(step_q);
			REG_DEBOUNCE: prdata = CFG_DW'(debounce_q);
			REG_IDLE:     prdata = CFG_DW'(idle_lim_q);
			REG_PRESENT:  prdata = CFG_DW'(present_q);
			default:      prdata = '0;
		endcase
	end

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign advance       = s_axis_tvalid && s_axis_tready;
	assign levels        = s_axis_tdata[NUM_KEYS-1:0];
	assign tick          = s_axis_tdata[NUM_KEYS+2];

	for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
		ttkc_key_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.advance     (advance),
			.present     (present_q[k]),
			.level       (levels[k]),
			.tick        (tick),
			.debounce_ms (debounce_q),
			.pressed     (pressed[k])
		);
	end

	always_comb begin
		smp.phase_a     = s_axis_tdata[NUM_KEYS];
		smp.phase_b     = s_axis_tdata[NUM_KEYS+1];
		smp.tick        = tick;
		smp.slow_held   = !levels[SLOW_KEY];
		scfg.mode       = mode_q;
		scfg.step       = step_q;
		scfg.idle_limit = idle_lim_q;
	end

	ttkc_scratch u_scratch (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.smp     (smp),
		.cfg     (scfg),
		.x_axis  (x_axis),
		.y_axis  (y_axis)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			m_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= OUT_W'({y_axis, x_axis, pressed});
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

`default_nettype wire

/* sv/ttkc_checker.sv */
// ----------------------------------------------------------------------------
// ttkc_checker
// Port-level checks on the report channel and its coupling to the sample side.
// ----------------------------------------------------------------------------
`default_nettype none

module ttkc_checker #(
	parameter int NUM_KEYS = ttkc_pkg::NUM_KEYS_DEF,
	localparam int OUT_W = ((NUM_KEYS + 16 + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             s_axis_tvalid,
	input wire logic             s_axis_tready,
	input wire logic             m_axis_tvalid,
	input wire logic             m_axis_tready,
	input wire logic [OUT_W-1:0] m_axis_tdata
);
	import ttkc_pkg::*;

	logic [7:0] x_field;
	logic [7:0] y_field;

	assign x_field = m_axis_tdata[NUM_KEYS+7:NUM_KEYS];
	assign y_field = m_axis_tdata[NUM_KEYS+15:NUM_KEYS+8];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("report item changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready == (!m_axis_tvalid || m_axis_tready))
		else $error("sample ready does not follow report slot");

	a_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted sample produced no report");

	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (x_field == 8'h00) || (y_field == 8'h00))
		else $error("both axes active in one report");

	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (y_field == 8'h00) || (y_field == 8'h7F) || (y_field == 8'h80))
		else $error("digital axis holds an illegal value");

endmodule

bind turntable_key_input_conditioner ttkc_checker #(.NUM_KEYS(NUM_KEYS)) u_ttkc_checker (.*);

`default_nettype wire
